// ----- hw/rtl/nmeagsa_pkg.sv -----
// Shared types and constants for the GSA sentence parser.
`default_nettype none

package nmeagsa_pkg;

    // Field numbers within a GSA sentence
    localparam logic [4:0] ID_FIRST  = 5'd3;
    localparam logic [4:0] ID_LAST   = 5'd14;
    localparam logic [4:0] DOP_FIRST = 5'd15;
    localparam logic [4:0] DOP_MID   = 5'd16;
    localparam logic [4:0] DOP_LAST  = 5'd17;
    localparam logic [4:0] SYS_FIELD = 5'd18;
    localparam logic [4:0] FIELD_MAX = 5'd31;

    // Value limits and defaults
    localparam logic [16:0] ACC_MAX      = 17'd131071;
    localparam logic [15:0] DOP_DEFAULT  = 16'd9999;
    localparam logic [15:0] DOP_MAX      = 16'd65535;
    localparam logic [9:0]  ID_MAX       = 10'd999;
    localparam logic [7:0]  SYS_MAX      = 8'd99;
    localparam logic [7:0]  SYS_DEFAULT  = 8'hFF;

    // Characters of interest
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Commands from controller to datapath
    typedef struct packed {
        logic take_byte;    // consume the accepted input word
        logic final_close;  // close the open field, latch the field-count check
        logic load_id;      // load one stored id into the output register
        logic load_sum;     // load the summary into the output register
        logic clear_all;    // return sentence state to reset values
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic ids_done;     // no more ids left to send
        logic slot_free;    // output register can take a word this cycle
    } t_sts;

endpackage

`default_nettype wire

// ----- hw/rtl/nmeagsa_ctrl.sv -----
// Sequencing state machine for the GSA sentence parser.
`default_nettype none

module nmeagsa_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  wire                i_in_eos,
    input  wire nmeagsa_pkg::t_sts i_sts,
    output logic               o_in_ready,
    output nmeagsa_pkg::t_cmd  o_cmd
);
    import nmeagsa_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FINAL = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_byte = 1'b1;
                    if (i_in_eos) begin
                        n_state = S_FINAL;
                    end
                end
            end
            S_FINAL: begin
                o_cmd.final_close = 1'b1;
                n_state           = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.slot_free) begin
                    if (!i_sts.ids_done) begin
                        o_cmd.load_id = 1'b1;
                    end else begin
                        o_cmd.load_sum  = 1'b1;
                        o_cmd.clear_all = 1'b1;
                        n_state         = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/nmeagsa_dpath.sv -----
// Field parsing, value store and output register for the GSA sentence parser.
`default_nettype none

module nmeagsa_dpath #(
    parameter int MAX_IDS         = 12,
    parameter int EXPECTED_FIELDS = 20
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire nmeagsa_pkg::t_cmd i_cmd,
    output nmeagsa_pkg::t_sts  o_sts,
    input  wire  [7:0]         i_byte_value,
    input  wire                i_out_ready,
    output logic               o_out_valid,
    output logic               o_is_summary,
    output logic [9:0]         o_satellite_id,
    output logic [15:0]        o_position_dop,
    output logic [15:0]        o_horizontal_dop,
    output logic [15:0]        o_vertical_dop,
    output logic signed [7:0]  o_gnss_system,
    output logic [3:0]         o_id_count,
    output logic               o_field_count_ok,
    output logic               o_last
);
    import nmeagsa_pkg::*;

    localparam int CW = $clog2(MAX_IDS + 1);
    localparam int IW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;

    // Sentence state
    logic [4:0]  r_field_index;
    logic [16:0] r_acc;
    logic [1:0]  r_frac;
    logic        r_digit_seen;
    logic        r_prefix_ended;
    logic        r_point_seen;
    logic        r_parse_stopped;
    logic [9:0]  r_id_store [MAX_IDS];
    logic [CW-1:0] r_id_cnt;
    logic [CW-1:0] r_rd_cnt;
    logic [15:0] r_pdop;
    logic [15:0] r_hdop;
    logic [15:0] r_vdop;
    logic [7:0]  r_system;
    logic        r_ok;
    logic        r_out_valid;

    logic [16:0] n_acc;
    logic [1:0]  n_frac;
    logic        n_digit_seen;
    logic        n_prefix_ended;
    logic        n_point_seen;

    logic        is_delim;
    logic        is_digit;
    logic [3:0]  digit;
    logic [7:0]  digit_wide;
    logic        in_id;
    logic        in_dop;
    logic        in_sys;
    logic        nonempty;
    logic        do_close;
    logic        commit_id;
    logic        commit_dop;
    logic        commit_sys;
    logic        stop_set;
    logic [20:0] acc_x10;
    logic [16:0] acc_sat;
    logic [23:0] dop_scaled;
    logic [15:0] dop_val;
    logic [9:0]  id_val;
    logic [7:0]  sys_val;
    logic [5:0]  field_total;

    // Character classes and field kind
    assign is_delim   = (i_byte_value == CH_COMMA) || (i_byte_value == CH_STAR);
    assign is_digit   = (i_byte_value >= CH_ZERO) && (i_byte_value <= CH_NINE);
    assign digit_wide = i_byte_value - CH_ZERO;
    assign digit      = digit_wide[3:0];
    assign in_id      = (r_field_index >= ID_FIRST) && (r_field_index <= ID_LAST);
    assign in_dop     = (r_field_index >= DOP_FIRST) && (r_field_index <= DOP_LAST);
    assign in_sys     = (r_field_index == SYS_FIELD);
    assign nonempty   = r_digit_seen || r_prefix_ended || r_point_seen;

    // Accumulator step: acc * 10 + digit, saturating
    assign acc_x10 = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {17'b0, digit};
    assign acc_sat = (acc_x10 > {4'b0, ACC_MAX}) ? ACC_MAX : acc_x10[16:0];

    // Scale to hundredths by the number of fraction digits
    always_comb begin
        case (r_frac)
            2'd0:    dop_scaled = {7'b0, r_acc} * 24'd100;
            2'd1:    dop_scaled = {7'b0, r_acc} * 24'd10;
            default: dop_scaled = {7'b0, r_acc};
        endcase
    end
    assign dop_val = (dop_scaled > {8'b0, DOP_MAX}) ? DOP_MAX : dop_scaled[15:0];
    assign id_val  = (r_acc > {7'b0, ID_MAX}) ? ID_MAX : r_acc[9:0];
    assign sys_val = (r_acc > {9'b0, SYS_MAX}) ? SYS_MAX : {1'b0, r_acc[6:0]};

    // Field close and commit decisions
    assign do_close   = (i_cmd.take_byte && is_delim) || i_cmd.final_close;
    assign commit_id  = do_close && !r_parse_stopped && in_id && nonempty && r_digit_seen
                        && (r_id_cnt < CW'(MAX_IDS));
    assign commit_dop = do_close && !r_parse_stopped && in_dop && r_digit_seen;
    assign commit_sys = do_close && !r_parse_stopped && in_sys && r_digit_seen;
    assign stop_set   = do_close && !r_parse_stopped && !r_digit_seen
                        && ((in_id && nonempty) || in_dop || in_sys);
    assign field_total = {1'b0, r_field_index} + 6'd1;

    // Numeric prefix scan of the open field
    always_comb begin
        n_acc          = r_acc;
        n_frac         = r_frac;
        n_digit_seen   = r_digit_seen;
        n_prefix_ended = r_prefix_ended;
        n_point_seen   = r_point_seen;
        if (i_cmd.clear_all || do_close) begin
            n_acc          = '0;
            n_frac         = '0;
            n_digit_seen   = 1'b0;
            n_prefix_ended = 1'b0;
            n_point_seen   = 1'b0;
        end else if (i_cmd.take_byte && !r_prefix_ended) begin
            if (is_digit) begin
                n_digit_seen = 1'b1;
                // third and later fraction digits are dropped
                if (!(r_point_seen && (r_frac >= 2'd2))) begin
                    if (r_point_seen) begin
                        n_frac = r_frac + 2'd1;
                    end
                    n_acc = acc_sat;
                end
            end else if ((i_byte_value == CH_POINT) && in_dop && !r_point_seen) begin
                n_point_seen = 1'b1;
            end else begin
                n_prefix_ended = 1'b1;
            end
        end
    end

    // Control and pending-value registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_index   <= '0;
            r_acc           <= '0;
            r_frac          <= '0;
            r_digit_seen    <= 1'b0;
            r_prefix_ended  <= 1'b0;
            r_point_seen    <= 1'b0;
            r_parse_stopped <= 1'b0;
            r_id_cnt        <= '0;
            r_rd_cnt        <= '0;
            r_pdop          <= DOP_DEFAULT;
            r_hdop          <= DOP_DEFAULT;
            r_vdop          <= DOP_DEFAULT;
            r_system        <= SYS_DEFAULT;
            r_ok            <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_acc          <= n_acc;
            r_frac         <= n_frac;
            r_digit_seen   <= n_digit_seen;
            r_prefix_ended <= n_prefix_ended;
            r_point_seen   <= n_point_seen;

            if (i_cmd.clear_all) begin
                r_field_index   <= '0;
                r_parse_stopped <= 1'b0;
                r_id_cnt        <= '0;
                r_pdop          <= DOP_DEFAULT;
                r_hdop          <= DOP_DEFAULT;
                r_vdop          <= DOP_DEFAULT;
                r_system        <= SYS_DEFAULT;
            end else begin
                if (do_close && (r_field_index != FIELD_MAX)) begin
                    r_field_index <= r_field_index + 5'd1;
                end
                if (stop_set) begin
                    r_parse_stopped <= 1'b1;
                end
                if (commit_id) begin
                    r_id_cnt <= r_id_cnt + CW'(1);
                end
                if (commit_dop) begin
                    if (r_field_index == DOP_FIRST) begin
                        r_pdop <= dop_val;
                    end else if (r_field_index == DOP_MID) begin
                        r_hdop <= dop_val;
                    end else begin
                        r_vdop <= dop_val;
                    end
                end
                if (commit_sys) begin
                    r_system <= sys_val;
                end
            end

            // Field-count check and id read pointer
            if (i_cmd.final_close) begin
                r_ok     <= (field_total == 6'(EXPECTED_FIELDS));
                r_rd_cnt <= '0;
            end else if (i_cmd.load_id) begin
                r_rd_cnt <= r_rd_cnt + CW'(1);
            end

            // Output word valid
            if (i_cmd.load_id || i_cmd.load_sum) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Id store
    always_ff @(posedge i_clk) begin
        if (commit_id) begin
            r_id_store[r_id_cnt[IW-1:0]] <= id_val;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_id) begin
            o_is_summary     <= 1'b0;
            o_satellite_id   <= r_id_store[r_rd_cnt[IW-1:0]];
            o_position_dop   <= '0;
            o_horizontal_dop <= '0;
            o_vertical_dop   <= '0;
            o_gnss_system    <= '0;
            o_id_count       <= '0;
            o_field_count_ok <= 1'b0;
            o_last           <= 1'b0;
        end else if (i_cmd.load_sum) begin
            o_is_summary     <= 1'b1;
            o_satellite_id   <= '0;
            o_position_dop   <= r_ok ? r_pdop : DOP_DEFAULT;
            o_horizontal_dop <= r_ok ? r_hdop : DOP_DEFAULT;
            o_vertical_dop   <= r_ok ? r_vdop : DOP_DEFAULT;
            o_gnss_system    <= r_ok ? signed'(r_system) : signed'(SYS_DEFAULT);
            o_id_count       <= r_ok ? 4'(r_id_cnt) : 4'd0;
            o_field_count_ok <= r_ok;
            o_last           <= 1'b1;
        end
    end

    // Status back to the controller
    assign o_sts.ids_done  = !r_ok || (r_rd_cnt >= r_id_cnt);
    assign o_sts.slot_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;

endmodule

`default_nettype wire

// ----- hw/rtl/nmea_gsa_sentence_parser_core.sv -----
// Top level of the GSA sentence parser: controller plus datapath.
//
// Input channel (i_in_valid / o_in_ready): one sentence character per word,
// with i_end_of_sentence set on the final character. While idle the block
// takes one character per clock; each character is folded into the open field
// in the cycle it is accepted and produces no output.
// After the final character, the closing state closes the last field and
// checks the field count; then one id word per cycle, while the output is
// not stalled (up to MAX_IDS), and a summary word with o_last set go into
// the output register. Input is not taken until the summary word is loaded.
// Output channel (o_out_valid / i_out_ready): a single output register. A
// stalled receiver holds the current word and the controller waits; the next
// sentence may start arriving while the summary word still waits.
// Fields 3..14 are ids, 15..17 the DOPs in hundredths, 18 the system id.
// A wrong field count gives only the summary with default values.
// Reset (synchronous, active low) clears all sentence state and o_out_valid,
// not the output payload; the id store holds no meaning until ids are written.
`default_nettype none

module nmea_gsa_sentence_parser_core #(
    parameter int MAX_IDS         = 12,
    parameter int EXPECTED_FIELDS = 20
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire  [7:0]        i_byte_value,
    input  wire               i_end_of_sentence,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic              o_is_summary,
    output logic [9:0]        o_satellite_id,
    output logic [15:0]       o_position_dop,
    output logic [15:0]       o_horizontal_dop,
    output logic [15:0]       o_vertical_dop,
    output logic signed [7:0] o_gnss_system,
    output logic [3:0]        o_id_count,
    output logic              o_field_count_ok,
    output logic              o_last
);
    import nmeagsa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    nmeagsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_eos   (i_end_of_sentence),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    nmeagsa_dpath #(
        .MAX_IDS         (MAX_IDS),
        .EXPECTED_FIELDS (EXPECTED_FIELDS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_byte_value     (i_byte_value),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_is_summary     (o_is_summary),
        .o_satellite_id   (o_satellite_id),
        .o_position_dop   (o_position_dop),
        .o_horizontal_dop (o_horizontal_dop),
        .o_vertical_dop   (o_vertical_dop),
        .o_gnss_system    (o_gnss_system),
        .o_id_count       (o_id_count),
        .o_field_count_ok (o_field_count_ok),
        .o_last           (o_last)
    );

    // An id word waiting at the output means the final run is still going
    a_id_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> !o_in_ready)
        else $error("input ready while id words are pending");

    // The final character starts the closing run
    a_eos_stops_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_end_of_sentence) |=> !o_in_ready)
        else $error("input taken right after the final character");

    // A summary load shows up as the last output word
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_sum |=> (o_out_valid && o_last && o_is_summary))
        else $error("summary word not presented as last");

endmodule

`default_nettype wire

// ----- verif/nmea_gsa_sentence_parser_core_tb.sv -----
// Testbench for the GSA sentence parser core: directed and random sentences, self-checking.
`timescale 1ns / 1ps

module nmea_gsa_sentence_parser_core_tb;
    import nmeagsa_pkg::*;

    localparam int MAX_IDS         = 12;
    localparam int EXPECTED_FIELDS = 20;

    // One output word as the block presents it
    typedef struct packed {
        logic       is_summary;
        logic [9:0] sat_id;
        logic [15:0] pdop;
        logic [15:0] hdop;
        logic [15:0] vdop;
        logic [7:0] system;
        logic [3:0] count;
        logic       count_ok;
        logic       last;
    } t_gsa_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic [7:0]        i_byte_value = 8'h00;
    logic              i_end_of_sentence = 1'b0;
    logic              i_out_ready = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic              o_is_summary;
    logic [9:0]        o_satellite_id;
    logic [15:0]       o_position_dop;
    logic [15:0]       o_horizontal_dop;
    logic [15:0]       o_vertical_dop;
    logic signed [7:0] o_gnss_system;
    logic [3:0]        o_id_count;
    logic              o_field_count_ok;
    logic              o_last;

    nmea_gsa_sentence_parser_core #(
        .MAX_IDS(MAX_IDS),
        .EXPECTED_FIELDS(EXPECTED_FIELDS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_byte_value(i_byte_value),
        .i_end_of_sentence(i_end_of_sentence),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_is_summary(o_is_summary),
        .o_satellite_id(o_satellite_id),
        .o_position_dop(o_position_dop),
        .o_horizontal_dop(o_horizontal_dop),
        .o_vertical_dop(o_vertical_dop),
        .o_gnss_system(o_gnss_system),
        .o_id_count(o_id_count),
        .o_field_count_ok(o_field_count_ok),
        .o_last(o_last)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Words to send: bit 8 is end of sentence
    logic [8:0] stim[$];
    logic [7:0] line_buf[$];
    int         n_taken = 0;
    int         mismatches = 0;
    t_gsa_word  expected_words[$];

    // Parser model state
    int         cur_field = 0;
    int         num_acc = 0;
    int         frac_cnt = 0;
    bit         has_digit = 1'b0;
    bit         prefix_done = 1'b0;
    bit         point_taken = 1'b0;
    bit         commit_off = 1'b0;
    logic [9:0] sat_ids[MAX_IDS];
    int         sat_count = 0;
    int         pdop_h = DOP_DEFAULT;
    int         hdop_h = DOP_DEFAULT;
    int         vdop_h = DOP_DEFAULT;
    int         sys_id = -1;

    // Queue appends
    task automatic add_byte(logic [7:0] b);
        line_buf = {line_buf, b};
    endtask

    task automatic add_word(logic [8:0] w);
        stim = {stim, w};
    endtask

    task automatic expect_word(t_gsa_word w);
        expected_words = {expected_words, w};
    endtask

    task automatic clear_field();
        num_acc = 0;
        frac_cnt = 0;
        has_digit = 1'b0;
        prefix_done = 1'b0;
        point_taken = 1'b0;
    endtask

    task automatic clear_sentence();
        cur_field = 0;
        clear_field();
        commit_off = 1'b0;
        sat_count = 0;
        pdop_h = DOP_DEFAULT;
        hdop_h = DOP_DEFAULT;
        vdop_h = DOP_DEFAULT;
        sys_id = -1;
    endtask

    // Fold one non-separator character into the numeric prefix
    task automatic take_char(logic [7:0] c);
        bit in_dop;
        in_dop = cur_field >= DOP_FIRST && cur_field <= DOP_LAST;
        if (!prefix_done) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                has_digit = 1'b1;
                if (!point_taken || frac_cnt < 2) begin
                    if (point_taken)
                        frac_cnt++;
                    num_acc = num_acc * 10 + int'(c - CH_ZERO);
                    if (num_acc > ACC_MAX)
                        num_acc = ACC_MAX;
                end
            end else if (c == CH_POINT && in_dop && !point_taken) begin
                point_taken = 1'b1;
            end else begin
                prefix_done = 1'b1;
            end
        end
    endtask

    // Commit the open field and step to the next one
    task automatic close_field();
        bit filled;
        int v;
        filled = has_digit || prefix_done || point_taken;
        if (!commit_off) begin
            if (cur_field >= ID_FIRST && cur_field <= ID_LAST) begin
                if (filled) begin
                    if (!has_digit) begin
                        commit_off = 1'b1;
                    end else if (sat_count < MAX_IDS) begin
                        sat_ids[sat_count] = (num_acc > ID_MAX) ? ID_MAX : 10'(num_acc);
                        sat_count++;
                    end
                end
            end else if (cur_field >= DOP_FIRST && cur_field <= DOP_LAST) begin
                if (!has_digit) begin
                    commit_off = 1'b1;
                end else begin
                    v = num_acc * ((frac_cnt == 0) ? 100 : (frac_cnt == 1) ? 10 : 1);
                    if (v > DOP_MAX)
                        v = DOP_MAX;
                    if (cur_field == DOP_FIRST)
                        pdop_h = v;
                    else if (cur_field == DOP_MID)
                        hdop_h = v;
                    else
                        vdop_h = v;
                end
            end else if (cur_field == SYS_FIELD) begin
                if (!has_digit)
                    commit_off = 1'b1;
                else
                    sys_id = (num_acc > SYS_MAX) ? SYS_MAX : num_acc;
            end
        end
        clear_field();
        if (cur_field < FIELD_MAX)
            cur_field++;
    endtask

    // Predict the words caused by one accepted input word
    task automatic parse_char(logic [7:0] c, logic eos);
        int        fields_seen;
        bit        ok;
        t_gsa_word w;
        if (c == CH_COMMA || c == CH_STAR)
            close_field();
        else
            take_char(c);
        if (eos) begin
            fields_seen = cur_field + 1;
            close_field();
            ok = fields_seen == EXPECTED_FIELDS;
            if (!ok) begin
                sat_count = 0;
                pdop_h = DOP_DEFAULT;
                hdop_h = DOP_DEFAULT;
                vdop_h = DOP_DEFAULT;
                sys_id = -1;
            end
            for (int k = 0; k < sat_count; k++) begin
                w = '{1'b0, sat_ids[k], 16'd0, 16'd0, 16'd0, 8'd0, 4'd0, 1'b0, 1'b0};
                expect_word(w);
            end
            w = '{1'b1, 10'd0, 16'(pdop_h), 16'(hdop_h), 16'(vdop_h),
                  8'(sys_id), 4'(sat_count), ok, 1'b1};
            expect_word(w);
            clear_sentence();
        end
    endtask

    // Idle percentages by traffic phase
    function automatic int traffic_phase();
        int p;
        p = (n_taken * 3) / stim.size();
        return (p > 2) ? 2 : p;
    endfunction

    function automatic int send_idle_pct();
        case (traffic_phase())
            0: return 22;
            1: return 73;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case (traffic_phase())
            0: return 73;
            1: return 22;
            default: return 0;
        endcase
    endfunction

    // Sentence building
    function automatic string digits(int n);
        string s;
        s = "";
        for (int k = 0; k < n; k++)
            s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        return s;
    endfunction

    function automatic string junk();
        string pool;
        int    k;
        pool = "-+ AZ#/:$";
        k = $urandom_range(0, pool.len() - 1);
        return pool.substr(k, k);
    endfunction

    function automatic string field_text(int idx);
        int    r;
        int    ni;
        int    nf;
        string s;
        r = $urandom_range(0, 99);
        s = "";
        if (idx >= ID_FIRST && idx <= ID_LAST) begin
            if (r < 40)
                s = "";
            else if (r < 88)
                s = digits($urandom_range(1, 3));
            else if (r < 94)
                s = digits($urandom_range(4, 7));
            else if (r < 99)
                s = {digits($urandom_range(1, 3)), junk()};
            else
                s = {junk(), digits(1)};
        end else if (idx >= DOP_FIRST && idx <= DOP_LAST) begin
            if (r < 85) begin
                ni = $urandom_range(0, 2);
                nf = $urandom_range(0, 4);
                if ($urandom_range(0, 4) != 0) begin
                    if (ni == 0 && nf == 0)
                        ni = 1;
                    s = {digits(ni), ".", digits(nf)};
                end else begin
                    s = digits((ni == 0) ? 1 : ni);
                end
            end else if (r < 93) begin
                s = {digits($urandom_range(4, 6)), ".", digits($urandom_range(0, 3))};
            end else if (r < 97) begin
                s = {digits(1), ".", digits(1), ".", digits(1)};
            end else if (r < 98) begin
                s = {junk(), digits(1), ".", digits(1)};
            end else if (r < 99) begin
                s = ".";
            end
        end else if (idx == SYS_FIELD) begin
            if (r < 90)
                s = digits($urandom_range(1, 3));
            else if (r < 97)
                s = {digits(1), junk()};
        end else if (idx == 0) begin
            s = (r < 50) ? "$GPGSA" : (r < 70) ? "$GNGSA" : "";
        end else if (idx == 1) begin
            s = (r < 50) ? "A" : "M";
        end else if (idx == 2) begin
            s = digits(1);
        end else if (idx == EXPECTED_FIELDS - 1) begin
            if (r < 85)
                s = $sformatf("%02X", $urandom_range(0, 255));
        end else if (r < 50) begin
            s = digits($urandom_range(1, 2));
        end
        return s;
    endfunction

    task automatic add_text(string s);
        for (int k = 0; k < s.len(); k++)
            add_byte(s[k]);
    endtask

    // Move the line into the send queue, flagging its last byte
    task automatic end_line();
        for (int k = 0; k < line_buf.size(); k++)
            add_word({k == line_buf.size() - 1, line_buf[k]});
        line_buf.delete();
    endtask

    task automatic build_sentence(int nfields);
        for (int k = 0; k < nfields; k++) begin
            add_text(field_text(k));
            if (k == nfields - 2)
                add_text(($urandom_range(0, 4) != 0) ? "*" : ",");
            else if (k < nfields - 2)
                add_text(($urandom_range(0, 49) == 0) ? "*" : ",");
        end
        if (line_buf.size() == 0)
            add_text(",");
        end_line();
    endtask

    task automatic build_noise();
        int n;
        n = $urandom_range(1, 30);
        for (int k = 0; k < n; k++)
            add_byte(($urandom_range(0, 99) < 20) ? CH_COMMA : 8'($urandom_range(0, 255)));
        end_line();
    endtask

    // Input driver
    always @(posedge i_clk) begin : in_driver
        bit taken;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            taken = i_in_valid && o_in_ready;
            if (taken) begin
                parse_char(i_byte_value, i_end_of_sentence);
                n_taken++;
            end
            if (!i_in_valid || taken) begin
                if (n_taken < stim.size() && $urandom_range(0, 99) >= send_idle_pct()) begin
                    i_in_valid <= 1'b1;
                    i_byte_value <= stim[n_taken][7:0];
                    i_end_of_sentence <= stim[n_taken][8];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= $urandom_range(0, 99) >= recv_idle_pct();
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Output monitor
    always @(posedge i_clk) begin : out_monitor
        t_gsa_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                $error("output word with none expected");
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                check_field("is_summary", want.is_summary, o_is_summary);
                check_field("satellite_id", want.sat_id, o_satellite_id);
                check_field("position_dop", want.pdop, o_position_dop);
                check_field("horizontal_dop", want.hdop, o_horizontal_dop);
                check_field("vertical_dop", want.vdop, o_vertical_dop);
                check_field("gnss_system", $signed(want.system), o_gnss_system);
                check_field("id_count", want.count, o_id_count);
                check_field("field_count_ok", want.count_ok, o_field_count_ok);
                check_field("last", want.last, o_last);
            end
        end
    end

    // Stimulus and end of run
    initial begin : run_main
        int r;
        int nf;
        int whole_count;
        whole_count = 0;

        // one-byte sentences at the byte extremes
        add_byte(8'hFF);
        end_line();
        add_byte(8'h00);
        end_line();
        // empty id, saturating id and DOPs, fraction truncation, system clamp
        add_text("$,A,3,0,999,1000,,5,6,7,8,9,1,2,3,655.35,0.999,1234567,255*F");
        end_line();
        // id field led by a sign stops later commits
        add_text(",,,7,-3,8,,,,,,,,,,1,1,1,1*");
        end_line();

        // mostly well-formed sentences, some with wrong counts, some noise
        while (stim.size() < 310 || whole_count < 3) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                build_sentence(EXPECTED_FIELDS);
                whole_count++;
            end else if (r < 85) begin
                nf = $urandom_range(1, 35);
                if (nf == EXPECTED_FIELDS)
                    nf++;
                build_sentence(nf);
            end else begin
                build_noise();
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (n_taken < stim.size() || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
